>>> rtl/box3_pkg.sv
// Shared types and constants for the 3x3 box stencil with zero padding.
// Used by every module of the block; depends on nothing else.
package box3_pkg;

    // Fixed widths of the stream fields and configuration registers.
    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

    // Grid size limits and the size taken after reset.
    localparam int SIZE_MIN      = 2;
    localparam int SIZE_RST      = 1024;
    localparam int DEF_MAX_COLS  = 1024;
    localparam int DEF_MAX_ROWS  = 1024;

    // One column of three samples, and the whole 3x3 neighbourhood.
    localparam int COL_SUM_W = SAMPLE_W + 2;
    localparam int SUM_W     = SAMPLE_W + 4;

    // Divide by nine as a multiply by a rounded-up reciprocal. The error of
    // the reciprocal times any sum stays below one unit of the shift.
    localparam int STENCIL_DIV = 9;
    localparam int DIV_SHIFT   = SUM_W + 3;
    localparam int DIV_MULT_W  = DIV_SHIFT - 2;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT =
        DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(STENCIL_DIV) - 64'd1) / 64'(STENCIL_DIV));

    // Control decided at acceptance and carried with the item.
    typedef struct packed {
        logic col_zero;   // first column: completes the previous row's last cell
        logic top_en;     // row above the middle line exists
        logic mid_en;     // middle line row exists
        logic emit;       // this item yields a result
        logic frame_end;  // the result is the last cell of the grid
        logic restart;    // position and window return to zero afterwards
    } item_ctl_t;

    // Neighbourhood sum waiting for the divide.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             row_end;
        logic             frame_end;
    } sum_item_t;

endpackage

>>> rtl/box_stencil_3x3_zero_pad.sv
// Top level of the 3x3 box stencil with zero padding.
// Depends on box3_pkg, box3_front, box3_line_store, box3_window and box3_div9.
//
// Smooths a grid streamed in raster order: each result is floor of the sum of
// the cell's 3x3 neighbourhood over nine, with cells outside the grid taken as
// zero. The block takes one item every clock cycle unless the output stalls;
// the result for cell (r,c) follows the item at (r+1,c+1), or the first item
// of row r+2 for the last column, through the input register, the sum
// register and the result register. Each line store is read and written once
// per item, on separate ports, which sets the one-item-per-cycle rate. After
// the rows_in_use*cols_in_use samples, send cols_in_use+1 drain items to flush
// the last row; the last result carries frame_end and the next item starts a
// new frame. The line stores are not cleared after reset and need no clearing
// pass. Write the grid size only while the block is idle; a write restarts the
// frame. m_tlast marks the last cell of each row.
module box_stencil_3x3_zero_pad import box3_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  logic                 s_tuser,   // [0] drain
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,   // [15:0] smoothed
    output logic                 m_tlast,   // row_end
    output logic                 m_tuser    // [0] frame_end
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic                s1_adv;
    logic                s1_valid;
    logic [COL_W-1:0]    s1_col;
    logic [SAMPLE_W-1:0] s1_x;
    item_ctl_t           s1_ctl;
    logic                rd_en;
    logic [COL_W-1:0]    rd_col;
    logic                win_clr;
    logic                wr_en;
    logic [SAMPLE_W-1:0] wr_upper;
    logic [SAMPLE_W-1:0] wr_middle;
    logic [SAMPLE_W-1:0] upper_q;
    logic [SAMPLE_W-1:0] middle_q;
    logic                s2_valid;
    logic                s2_ready;
    sum_item_t           s2_item;

    // Position tracking and input register.
    box3_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s1_adv    (s1_adv),
        .s1_valid  (s1_valid),
        .s1_col    (s1_col),
        .s1_x      (s1_x),
        .s1_ctl    (s1_ctl),
        .rd_en     (rd_en),
        .rd_col    (rd_col),
        .win_clr   (win_clr)
    );

    // Rows above the current one.
    box3_line_store #(
        .MAX_COLS (MAX_COLS)
    ) u_lines (
        .aclk      (aclk),
        .rd_en     (rd_en),
        .rd_col    (rd_col),
        .wr_en     (wr_en),
        .wr_col    (s1_col),
        .wr_upper  (wr_upper),
        .wr_middle (wr_middle),
        .upper_q   (upper_q),
        .middle_q  (middle_q)
    );

    // Window and neighbourhood sum.
    box3_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s1_valid  (s1_valid),
        .s1_x      (s1_x),
        .s1_ctl    (s1_ctl),
        .upper_q   (upper_q),
        .middle_q  (middle_q),
        .win_clr   (win_clr),
        .s2_ready  (s2_ready),
        .s1_adv    (s1_adv),
        .wr_en     (wr_en),
        .wr_upper  (wr_upper),
        .wr_middle (wr_middle),
        .s2_valid  (s2_valid),
        .s2_item   (s2_item)
    );

    // Divide and result register.
    box3_div9 u_div9 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s2_valid  (s2_valid),
        .s2_item   (s2_item),
        .s2_ready  (s2_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

>>> rtl/box3_front.sv
// Input register, raster position counters and grid size registers.
// Depends on box3_pkg.
module box3_front import box3_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [SAMPLE_W-1:0]          s_tdata,
    input  logic                         s_tuser,
    input  logic                         s1_adv,
    output logic                         s1_valid,
    output logic [$clog2(MAX_COLS)-1:0]  s1_col,
    output logic [SAMPLE_W-1:0]          s1_x,
    output item_ctl_t                    s1_ctl,
    output logic                         rd_en,
    output logic [$clog2(MAX_COLS)-1:0]  rd_col,
    output logic                         win_clr
);

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int COLS_W  = $clog2(MAX_COLS + 1);
    localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
    localparam int ROW_W   = $clog2(MAX_ROWS + 3);
    localparam int CMPC_W  = (COLS_W > CFG_W) ? COLS_W : CFG_W;
    localparam int CMPR_W  = (ROWS_W > CFG_W) ? ROWS_W : CFG_W;
    localparam int COLS_RST = (SIZE_RST > MAX_COLS) ? MAX_COLS : SIZE_RST;
    localparam int ROWS_RST = (SIZE_RST > MAX_ROWS) ? MAX_ROWS : SIZE_RST;

    logic [COLS_W-1:0]   cols_reg, cols_next;
    logic [ROWS_W-1:0]   rows_reg, rows_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]    s1_col_reg;
    logic [SAMPLE_W-1:0] s1_x_reg;
    item_ctl_t           s1_ctl_reg;

    logic                accept;
    logic                cfg_write;
    logic [CMPC_W-1:0]   cfg_cols_ext;
    logic [CMPR_W-1:0]   cfg_rows_ext;
    logic [COLS_W-1:0]   cols_clamped;
    logic [ROWS_W-1:0]   rows_clamped;
    logic [ROW_W-1:0]    rows_ext;
    logic [ROW_W-1:0]    rows_p1;
    logic [COLS_W-1:0]   col_inc;
    item_ctl_t           ctl;
    logic [SAMPLE_W-1:0] x;

    // Write the registers only while the block is idle; the block does not enforce it.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       ((cfg_index == REG_COLS) || (cfg_index == REG_ROWS));
    assign win_clr   = cfg_write;

    // The input register frees up as soon as the sum stage takes its item.
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;
    assign rd_en    = accept;
    assign rd_col   = col_reg;

    // Clamp written sizes into the supported range.
    always_comb begin
        cfg_cols_ext = CMPC_W'(cfg_data);
        cfg_rows_ext = CMPR_W'(cfg_data);
        if (cfg_cols_ext < CMPC_W'(SIZE_MIN)) begin
            cols_clamped = COLS_W'(SIZE_MIN);
        end else if (cfg_cols_ext > CMPC_W'(MAX_COLS)) begin
            cols_clamped = COLS_W'(MAX_COLS);
        end else begin
            cols_clamped = COLS_W'(cfg_cols_ext);
        end
        if (cfg_rows_ext < CMPR_W'(SIZE_MIN)) begin
            rows_clamped = ROWS_W'(SIZE_MIN);
        end else if (cfg_rows_ext > CMPR_W'(MAX_ROWS)) begin
            rows_clamped = ROWS_W'(MAX_ROWS);
        end else begin
            rows_clamped = ROWS_W'(cfg_rows_ext);
        end
    end

    // Decide what this position contributes and whether it yields a result.
    always_comb begin
        rows_ext      = ROW_W'(rows_reg);
        rows_p1       = rows_ext + ROW_W'(1);
        ctl.col_zero  = (col_reg == '0);
        ctl.mid_en    = (row_reg != '0);
        ctl.top_en    = (row_reg >= ROW_W'(2));
        if (ctl.col_zero) begin
            ctl.emit = ctl.top_en && (row_reg <= rows_p1);
        end else begin
            ctl.emit = ctl.mid_en && (row_reg <= rows_ext);
        end
        ctl.frame_end = ctl.col_zero && (row_reg == rows_p1);
        ctl.restart   = ctl.frame_end || (row_reg > rows_p1);
        x = (s_tuser || (row_reg >= rows_ext)) ? '0 : s_tdata;
    end

    // Next raster position and size registers.
    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        col_inc   = COLS_W'(col_reg) + COLS_W'(1);
        if (cfg_write) begin
            if (cfg_index == REG_COLS) begin
                cols_next = cols_clamped;
            end else begin
                rows_next = rows_clamped;
            end
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (ctl.restart) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc == cols_reg) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // Input register occupancy.
    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg     <= COLS_W'(COLS_RST);
            rows_reg     <= ROWS_W'(ROWS_RST);
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            cols_reg     <= cols_next;
            rows_reg     <= rows_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Item payload held until the sum stage takes it.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg <= col_reg;
            s1_x_reg   <= x;
            s1_ctl_reg <= ctl;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_col   = s1_col_reg;
    assign s1_x     = s1_x_reg;
    assign s1_ctl   = s1_ctl_reg;

endmodule

>>> rtl/box3_line_store.sv
// Two line stores holding the two rows above the current input row.
// Depends on box3_pkg.
module box3_line_store import box3_pkg::*; #(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_COLS)-1:0]  rd_col,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]  wr_col,
    input  logic [SAMPLE_W-1:0]          wr_upper,
    input  logic [SAMPLE_W-1:0]          wr_middle,
    output logic [SAMPLE_W-1:0]          upper_q,
    output logic [SAMPLE_W-1:0]          middle_q
);

    logic [SAMPLE_W-1:0] upper_mem  [MAX_COLS];
    logic [SAMPLE_W-1:0] middle_mem [MAX_COLS];
    logic [SAMPLE_W-1:0] upper_q_reg;
    logic [SAMPLE_W-1:0] middle_q_reg;

    // Read at the column of the item being accepted.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            upper_q_reg  <= upper_mem[rd_col];
            middle_q_reg <= middle_mem[rd_col];
        end
    end

    // Shift the column down one line when the item leaves the input register.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_col]  <= wr_upper;
            middle_mem[wr_col] <= wr_middle;
        end
    end

    assign upper_q  = upper_q_reg;
    assign middle_q = middle_q_reg;

endmodule

>>> rtl/box3_window.sv
// Sliding window of two column sums and the neighbourhood sum register.
// Depends on box3_pkg.
module box3_window import box3_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s1_valid,
    input  logic [SAMPLE_W-1:0]  s1_x,
    input  item_ctl_t            s1_ctl,
    input  logic [SAMPLE_W-1:0]  upper_q,
    input  logic [SAMPLE_W-1:0]  middle_q,
    input  logic                 win_clr,
    input  logic                 s2_ready,
    output logic                 s1_adv,
    output logic                 wr_en,
    output logic [SAMPLE_W-1:0]  wr_upper,
    output logic [SAMPLE_W-1:0]  wr_middle,
    output logic                 s2_valid,
    output sum_item_t            s2_item
);

    logic [COL_SUM_W-1:0] col1_reg, col1_next;
    logic [COL_SUM_W-1:0] col2_reg, col2_next;
    logic                 s2_valid_reg, s2_valid_next;
    sum_item_t            s2_item_reg;

    logic [SAMPLE_W-1:0]  top;
    logic [SAMPLE_W-1:0]  mid;
    logic [COL_SUM_W-1:0] cur;
    logic [SUM_W-1:0]     win_sum;
    logic                 fire;
    sum_item_t            item;

    assign s1_adv = !s2_valid_reg || s2_ready;
    assign fire   = s1_valid && s1_adv;

    // Rows above the grid read as zero.
    assign top = s1_ctl.top_en ? upper_q : '0;
    assign mid = s1_ctl.mid_en ? middle_q : '0;

    assign wr_en     = fire;
    assign wr_upper  = mid;
    assign wr_middle = s1_x;

    // The first column closes the previous row, whose right neighbour is padding.
    always_comb begin
        cur     = COL_SUM_W'(top) + COL_SUM_W'(mid) + COL_SUM_W'(s1_x);
        win_sum = SUM_W'(col1_reg) + SUM_W'(col2_reg);
        if (!s1_ctl.col_zero) begin
            win_sum = win_sum + SUM_W'(cur);
        end
        item.sum       = win_sum;
        item.row_end   = s1_ctl.col_zero;
        item.frame_end = s1_ctl.frame_end;
    end

    // Window shift; a new row starts with an empty left column.
    always_comb begin
        col1_next = col1_reg;
        col2_next = col2_reg;
        if (win_clr) begin
            col1_next = '0;
            col2_next = '0;
        end else if (fire) begin
            if (s1_ctl.restart) begin
                col1_next = '0;
                col2_next = '0;
            end else begin
                col1_next = cur;
                col2_next = s1_ctl.col_zero ? '0 : col1_reg;
            end
        end
    end

    // Sum register occupancy: only items that yield a result enter it.
    always_comb begin
        if (s1_adv) begin
            s2_valid_next = s1_valid && s1_ctl.emit;
        end else begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col1_reg     <= '0;
            col2_reg     <= '0;
            s2_valid_reg <= 1'b0;
        end else begin
            col1_reg     <= col1_next;
            col2_reg     <= col2_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            s2_item_reg <= item;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_item  = s2_item_reg;

endmodule

>>> rtl/box3_div9.sv
// Divide-by-nine stage and the result register of the output stream.
// Depends on box3_pkg.
module box3_div9 import box3_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s2_valid,
    input  sum_item_t            s2_item,
    output logic                 s2_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SAMPLE_W-1:0]  m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    localparam int PROD_W = SUM_W + DIV_MULT_W;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;
    logic                m_tuser_reg;
    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W-1:0] quotient;

    assign s2_ready = !m_tvalid_reg || m_tready;

    // floor(sum / 9) by reciprocal multiply; exact over the whole sum range.
    assign product  = PROD_W'(s2_item.sum) * PROD_W'(DIV_MULT);
    assign quotient = product[DIV_SHIFT +: SAMPLE_W];

    always_comb begin
        if (s2_ready) begin
            m_tvalid_next = s2_valid;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid && s2_ready) begin
            m_tdata_reg <= quotient;
            m_tlast_reg <= s2_item.row_end;
            m_tuser_reg <= s2_item.frame_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> rtl/box3_checker.sv
// Port-level checks on the result stream of the 3x3 box stencil.
// Depends on box3_pkg; bound to box_stencil_3x3_zero_pad below.
module box3_checker import box3_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata,
    input logic                m_tlast,
    input logic                m_tuser
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled item is held unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tlast) && $stable(m_tuser))
        else $error("stalled result item changed");

    // The last cell of the grid is also the last cell of its row.
    a_frame_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without row end");

    // Rows are at least two cells wide, so row ends never follow each other.
    a_row_end_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !(m_tvalid && m_tlast))
        else $error("two row ends in succession");

endmodule

bind box_stencil_3x3_zero_pad box3_checker u_box3_checker (.*);
